### src/tsae_pkg.sv
// Shared types, codes and element-type helpers for the typed shift array engine.
`timescale 1ns / 1ps

package tsae_pkg;

    localparam int TSAE_DEPTH = 256;
    localparam int CNT_W      = 17;
    localparam int POS_W      = 16;
    localparam int VAL_W      = 64;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    // Request kinds
    localparam logic [2:0] KIND_GET    = 3'd0;
    localparam logic [2:0] KIND_SET    = 3'd1;
    localparam logic [2:0] KIND_INSERT = 3'd2;
    localparam logic [2:0] KIND_REMOVE = 3'd3;
    localparam logic [2:0] KIND_POP    = 3'd4;
    localparam logic [2:0] KIND_TAIL   = 3'd5;
    localparam logic [2:0] KIND_CLEAR  = 3'd6;

    // Element types
    localparam logic [3:0] TYPE_INT8   = 4'd0;
    localparam logic [3:0] TYPE_UINT8  = 4'd1;
    localparam logic [3:0] TYPE_INT16  = 4'd2;
    localparam logic [3:0] TYPE_UINT16 = 4'd3;
    localparam logic [3:0] TYPE_INT32  = 4'd4;
    localparam logic [3:0] TYPE_UINT32 = 4'd5;
    localparam logic [3:0] TYPE_INT64  = 4'd6;
    localparam logic [3:0] TYPE_UINT64 = 4'd7;
    localparam logic [3:0] TYPE_FLOAT  = 4'd8;
    localparam logic [3:0] TYPE_DOUBLE = 4'd9;

    // Result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_BAD  = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    // Register index of the element type register
    localparam logic REG_ELEMENT_TYPE = 1'b0;

    typedef struct packed {
        logic [2:0]       kind;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value_in;
    } req_t;

    typedef struct packed {
        logic [VAL_W-1:0] value_out;
        logic [1:0]       status;
        logic [CNT_W-1:0] count;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SHIFT
    } state_t;

    typedef enum logic [3:0] {
        PLAN_BAD,
        PLAN_FULL,
        PLAN_GET,
        PLAN_SET,
        PLAN_INSERT,
        PLAN_REMOVE,
        PLAN_POP,
        PLAN_TAIL,
        PLAN_CLEAR
    } plan_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLEAR
    } cnt_op_t;

    typedef struct packed {
        logic    latch;
        logic    rd_issue;
        logic    rd_tail;
        logic    shift_init;
        logic    shift_step;
        logic    wr_value;
        cnt_op_t cnt_op;
        logic    finish;
    } ctrl_cmd_t;

    typedef struct packed {
        plan_t plan;
        logic  shift_done;
    } dp_status_t;

    function automatic logic [VAL_W-1:0] truncate_value(input logic [VAL_W-1:0] v,
                                                        input logic [3:0] t);
        logic [VAL_W-1:0] r;
        unique case (t)
            TYPE_INT8, TYPE_UINT8:                r = {56'd0, v[7:0]};
            TYPE_INT16, TYPE_UINT16:              r = {48'd0, v[15:0]};
            TYPE_INT32, TYPE_UINT32, TYPE_FLOAT:  r = {32'd0, v[31:0]};
            default:                              r = v;
        endcase
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] extend_value(input logic [VAL_W-1:0] v,
                                                      input logic [3:0] t);
        logic [VAL_W-1:0] r;
        unique case (t)
            TYPE_INT8:                r = {{56{v[7]}}, v[7:0]};
            TYPE_UINT8:               r = {56'd0, v[7:0]};
            TYPE_INT16:               r = {{48{v[15]}}, v[15:0]};
            TYPE_UINT16:              r = {48'd0, v[15:0]};
            TYPE_INT32:               r = {{32{v[31]}}, v[31:0]};
            TYPE_UINT32, TYPE_FLOAT:  r = {32'd0, v[31:0]};
            default:                  r = v;
        endcase
        return r;
    endfunction

endpackage

### src/typed_shift_array_engine_core.sv
// Top level of the typed shift array engine: register port, controller and datapath.
`timescale 1ns / 1ps
//
// A typed array of up to DEPTH 64-bit elements with a fill count.
// A request (kind, position, value_in) is taken at a rising edge where start is
// high and busy is low. Each request gives exactly one result (value_out,
// status, count), shown on result for a single cycle while done is high; the
// receiver cannot hold it off, so it must take it in that cycle.
// Set, clear and rejected requests finish from the execute state; get, pop and
// tail pass through the read state; insert and remove pass through the shift
// loop, which moves count - position elements for insert (position clamped to
// count) and count - position - 1 for remove. The next request may be taken in
// the done cycle. The move loop runs through the element memory's one read and
// one write port, one element per cycle.
// The element type register sits at byte address 0 of the APB port (pready is
// always high). It must be written only while the block is idle; the block
// itself does not enforce this.
// Reset clears the fill count, the element type (int8) and the control state;
// the element memory itself is not cleared and needs no clearing pass.
//
module typed_shift_array_engine_core
    import tsae_pkg::*;
#(
    parameter int DEPTH = TSAE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  req_t              request,
    output logic              done,
    output res_t              result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [3:0] element_type_reg;
    logic       cfg_write;
    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_type_reg <= TYPE_INT8;
        end
        else if (cfg_write && (paddr[2] == REG_ELEMENT_TYPE))
        begin
            element_type_reg <= pwdata[3:0];
        end
    end

    assign prdata = (paddr[2] == REG_ELEMENT_TYPE) ? APB_DW'(element_type_reg) : '0;

    tsae_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    tsae_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .element_type (element_type_reg),
        .cmd          (cmd),
        .dp_status    (dp_status),
        .done         (done),
        .result       (result)
    );

endmodule

### src/tsae_ctrl.sv
// Controller state machine that sequences each request through the datapath.
`timescale 1ns / 1ps

module tsae_ctrl
    import tsae_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  dp_status_t dp_status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.cnt_op = CNT_HOLD;
        busy       = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                unique case (dp_status.plan)
                    PLAN_GET:
                    begin
                        cmd.rd_issue = 1'b1;
                        state_next   = ST_READ;
                    end
                    PLAN_POP, PLAN_TAIL:
                    begin
                        cmd.rd_issue = 1'b1;
                        cmd.rd_tail  = 1'b1;
                        state_next   = ST_READ;
                    end
                    PLAN_SET:
                    begin
                        cmd.wr_value = 1'b1;
                        cmd.finish   = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    PLAN_INSERT, PLAN_REMOVE:
                    begin
                        cmd.shift_init = 1'b1;
                        state_next     = ST_SHIFT;
                    end
                    PLAN_CLEAR:
                    begin
                        cmd.cnt_op = CNT_CLEAR;
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_READ:
            begin
                cmd.finish = 1'b1;
                if (dp_status.plan == PLAN_POP)
                begin
                    cmd.cnt_op = CNT_DEC;
                end
                state_next = ST_IDLE;
            end

            ST_SHIFT:
            begin
                if (dp_status.shift_done)
                begin
                    // The write port is free once the last moved element has landed.
                    cmd.finish = 1'b1;
                    if (dp_status.plan == PLAN_INSERT)
                    begin
                        cmd.wr_value = 1'b1;
                        cmd.cnt_op   = CNT_INC;
                    end
                    else
                    begin
                        cmd.cnt_op = CNT_DEC;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.shift_step = 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### src/tsae_datapath.sv
// Datapath: element memory, fill count, shift sequencer registers and result register.
`timescale 1ns / 1ps

module tsae_datapath
    import tsae_pkg::*;
#(
    parameter int DEPTH = TSAE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  req_t       request,
    input  logic [3:0] element_type,
    input  ctrl_cmd_t  cmd,
    output dp_status_t dp_status,
    output logic       done,
    output res_t       result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [VAL_W-1:0] mem [DEPTH];

    req_t             req_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [AW-1:0]    cursor_reg;
    logic [AW-1:0]    cursor_next;
    logic [CW-1:0]    remain_reg;
    logic [CW-1:0]    remain_next;
    logic             pend_valid_reg;
    logic             pend_valid_next;
    logic [AW-1:0]    pend_addr_reg;
    logic [AW-1:0]    pend_addr_next;
    logic [VAL_W-1:0] rd_reg;
    logic             done_reg;
    res_t             result_reg;
    res_t             result_next;

    logic [CNT_W-1:0] count_ext;
    logic [CNT_W-1:0] pos_ext;
    logic [CNT_W-1:0] pos_clamp;
    logic             pos_in_range;
    logic             shift_up;
    logic             step_read;
    plan_t            plan;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;

    assign count_ext    = CNT_W'(count_reg);
    assign pos_ext      = CNT_W'(req_reg.position);
    assign pos_in_range = (pos_ext < count_ext);
    // An insert beyond the end appends.
    assign pos_clamp    = (pos_ext > count_ext) ? count_ext : pos_ext;
    assign shift_up     = (plan == PLAN_INSERT);
    assign step_read    = cmd.shift_step && (remain_reg != '0);

    always_comb
    begin
        unique case (req_reg.kind)
            KIND_GET:    plan = pos_in_range ? PLAN_GET : PLAN_BAD;
            KIND_SET:    plan = pos_in_range ? PLAN_SET : PLAN_BAD;
            KIND_INSERT: plan = (count_reg == CW'(DEPTH)) ? PLAN_FULL : PLAN_INSERT;
            KIND_REMOVE: plan = pos_in_range ? PLAN_REMOVE : PLAN_BAD;
            KIND_POP:    plan = (count_reg != '0) ? PLAN_POP : PLAN_BAD;
            KIND_TAIL:   plan = (count_reg != '0) ? PLAN_TAIL : PLAN_BAD;
            KIND_CLEAR:  plan = PLAN_CLEAR;
            default:     plan = PLAN_BAD;
        endcase
    end

    assign dp_status.plan       = plan;
    assign dp_status.shift_done = (remain_reg == '0) && !pend_valid_reg;

    // Shift sequencer: each step reads one element while any remain and writes the one read in the step before.
    always_comb
    begin
        cursor_next     = cursor_reg;
        remain_next     = remain_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;

        if (cmd.shift_init)
        begin
            pend_valid_next = 1'b0;
            if (shift_up)
            begin
                cursor_next = count_reg[AW-1:0] - AW'(1);
                remain_next = count_reg - pos_clamp[CW-1:0];
            end
            else
            begin
                cursor_next = pos_ext[AW-1:0] + AW'(1);
                remain_next = count_reg - CW'(1) - pos_ext[CW-1:0];
            end
        end
        else if (cmd.shift_step)
        begin
            pend_valid_next = step_read;
            if (step_read)
            begin
                remain_next = remain_reg - CW'(1);
                if (shift_up)
                begin
                    pend_addr_next = cursor_reg + AW'(1);
                    cursor_next    = cursor_reg - AW'(1);
                end
                else
                begin
                    pend_addr_next = cursor_reg - AW'(1);
                    cursor_next    = cursor_reg + AW'(1);
                end
            end
        end
    end

    always_comb
    begin
        mem_we    = cmd.wr_value || (cmd.shift_step && pend_valid_reg);
        mem_waddr = cmd.wr_value ? pos_clamp[AW-1:0] : pend_addr_reg;
        mem_wdata = cmd.wr_value ? truncate_value(req_reg.value_in, element_type) : rd_reg;

        mem_re    = cmd.rd_issue || step_read;
        if (cmd.rd_issue)
        begin
            mem_raddr = cmd.rd_tail ? count_reg[AW-1:0] - AW'(1) : pos_ext[AW-1:0];
        end
        else
        begin
            mem_raddr = cursor_reg;
        end
    end

    always_comb
    begin
        unique case (cmd.cnt_op)
            CNT_INC:   count_next = count_reg + CW'(1);
            CNT_DEC:   count_next = count_reg - CW'(1);
            CNT_CLEAR: count_next = '0;
            default:   count_next = count_reg;
        endcase
    end

    always_comb
    begin
        result_next       = result_reg;
        result_next.count = CNT_W'(count_next);
        unique case (plan)
            PLAN_GET, PLAN_POP, PLAN_TAIL:
            begin
                result_next.value_out = extend_value(rd_reg, element_type);
                result_next.status    = STATUS_OK;
            end
            PLAN_BAD:
            begin
                result_next.value_out = '0;
                result_next.status    = STATUS_BAD;
            end
            PLAN_FULL:
            begin
                result_next.value_out = '0;
                result_next.status    = STATUS_FULL;
            end
            default:
            begin
                result_next.value_out = '0;
                result_next.status    = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= request;
        end
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
        cursor_reg    <= cursor_next;
        pend_addr_reg <= pend_addr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            remain_reg     <= '0;
            pend_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            remain_reg     <= remain_next;
            pend_valid_reg <= pend_valid_next;
            done_reg       <= cmd.finish;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### tb/tb_typed_shift_array_engine_core.sv
// Self-checking testbench for the typed shift array engine: directed and random requests.
`timescale 1ns / 1ps

module tb_typed_shift_array_engine_core;
    import tsae_pkg::*;

    localparam int          CLK_PERIOD    = 12;
    localparam int          STORE_DEPTH   = TSAE_DEPTH;
    localparam int          QUIET_LIMIT   = 4000;
    localparam int          TAIL_CYCLES   = 8;
    localparam logic [2:0]  KIND_UNDEFINED = 3'd7;
    localparam logic [APB_AW-1:0] ADDR_ELEMENT_TYPE = APB_AW'(4 * REG_ELEMENT_TYPE);
    localparam logic [APB_AW-1:0] ADDR_UNMAPPED     = APB_AW'(4);

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    req_t              request;
    logic              done;
    res_t              result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Mirror of the array contents, fill count and element type.
    logic [VAL_W-1:0]  mirror_store [STORE_DEPTH];
    int                mirror_fill;
    logic [3:0]        mirror_type;

    res_t              outcome_q [$];
    int                fail_count;
    int                quiet_cycles;

    typed_shift_array_engine_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic int elem_bits(input logic [3:0] t);
        case (t)
            TYPE_INT8, TYPE_UINT8:               return 8;
            TYPE_INT16, TYPE_UINT16:             return 16;
            TYPE_INT32, TYPE_UINT32, TYPE_FLOAT: return 32;
            default:                             return 64;
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] elem_mask(input logic [3:0] t);
        int w;
        w = elem_bits(t);
        return (w == 64) ? {VAL_W{1'b1}} : ((64'd1 << w) - 64'd1);
    endfunction

    function automatic logic [VAL_W-1:0] widen_elem(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] m;
        logic [VAL_W-1:0] r;
        int               w;
        bit               is_signed;
        m = elem_mask(mirror_type);
        w = elem_bits(mirror_type);
        is_signed = (mirror_type == TYPE_INT8) || (mirror_type == TYPE_INT16) ||
                    (mirror_type == TYPE_INT32) || (mirror_type == TYPE_INT64);
        r = v & m;
        if (w < 64 && is_signed && r[w-1])
            r = r | ~m;
        return r;
    endfunction

    // Applies one request to the mirror and returns the result it should give.
    function automatic res_t predict_outcome(input req_t r);
        res_t o;
        int   p;
        int   i;
        o.value_out = '0;
        o.status    = STATUS_OK;
        p = int'(r.position);
        case (r.kind)
            KIND_GET:
                if (p < mirror_fill)
                    o.value_out = widen_elem(mirror_store[p]);
                else
                    o.status = STATUS_BAD;
            KIND_SET:
                if (p < mirror_fill)
                    mirror_store[p] = r.value_in & elem_mask(mirror_type);
                else
                    o.status = STATUS_BAD;
            KIND_INSERT:
                if (mirror_fill >= STORE_DEPTH)
                    o.status = STATUS_FULL;
                else
                begin
                    if (p > mirror_fill)
                        p = mirror_fill;
                    for (i = mirror_fill; i > p; i--)
                        mirror_store[i] = mirror_store[i-1];
                    mirror_store[p] = r.value_in & elem_mask(mirror_type);
                    mirror_fill++;
                end
            KIND_REMOVE:
                if (p < mirror_fill)
                begin
                    for (i = p; i + 1 < mirror_fill; i++)
                        mirror_store[i] = mirror_store[i+1];
                    mirror_fill--;
                end
                else
                    o.status = STATUS_BAD;
            KIND_POP, KIND_TAIL:
                if (mirror_fill > 0)
                begin
                    o.value_out = widen_elem(mirror_store[mirror_fill-1]);
                    if (r.kind == KIND_POP)
                        mirror_fill--;
                end
                else
                    o.status = STATUS_BAD;
            KIND_CLEAR:
                mirror_fill = 0;
            default:
                o.status = STATUS_BAD;
        endcase
        o.count = CNT_W'(mirror_fill);
        return o;
    endfunction

    function automatic req_t make_req(input logic [2:0] k, input logic [POS_W-1:0] p,
                                      input logic [VAL_W-1:0] v);
        req_t r;
        r.kind     = k;
        r.position = p;
        r.value_in = v;
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] random_value();
        case ($urandom_range(9))
            0:       return {VAL_W{1'b1}};
            1:       return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Random request whose mix pulls the fill count towards the given target.
    function automatic req_t random_request(input int target);
        req_t r;
        int   d;
        int   k;
        d = $urandom_range(99);
        if (mirror_fill < target)
            k = (d < 36) ? KIND_INSERT : (d < 56) ? KIND_GET : (d < 68) ? KIND_SET :
                (d < 80) ? KIND_REMOVE : (d < 88) ? KIND_POP : (d < 95) ? KIND_TAIL :
                (d < 97) ? KIND_CLEAR : KIND_UNDEFINED;
        else
            k = (d < 15) ? KIND_INSERT : (d < 35) ? KIND_GET : (d < 45) ? KIND_SET :
                (d < 70) ? KIND_REMOVE : (d < 85) ? KIND_POP : (d < 93) ? KIND_TAIL :
                (d < 97) ? KIND_CLEAR : KIND_UNDEFINED;
        r.kind = 3'(k);
        d = $urandom_range(99);
        if (d < 80)
            r.position = POS_W'($urandom_range(mirror_fill));
        else if (d < 95)
            r.position = POS_W'($urandom);
        else
            r.position = {POS_W{1'b1}};
        r.value_in = random_value();
        return r;
    endfunction

    // Presents one request and waits until the block takes it.
    task automatic send_request(input req_t r);
        @(negedge clk);
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        outcome_q.push_back(predict_outcome(r));
    endtask

    task automatic pause_sender(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
    endtask

    // One APB transfer; a read of the type register is checked against the mirror.
    task automatic apb_transfer(input logic [APB_AW-1:0] addr, input bit wr,
                                input logic [APB_DW-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (wr && addr == ADDR_ELEMENT_TYPE)
            mirror_type = data[3:0];
        if (!wr && prdata !== {{(APB_DW-4){1'b0}}, mirror_type})
        begin
            $error("element_type: expected %h, actual %h", mirror_type, prdata);
            fail_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_element_type(input logic [3:0] t);
        drain_results();
        apb_transfer(ADDR_ELEMENT_TYPE, 1'b1, {$urandom} & ~32'hF | {28'd0, t});
        apb_transfer(ADDR_ELEMENT_TYPE, 1'b0, '0);
    endtask

    task automatic test_empty_store();
        send_request(make_req(KIND_GET, '0, '0));
        send_request(make_req(KIND_SET, '0, {VAL_W{1'b1}}));
        send_request(make_req(KIND_REMOVE, '0, '0));
        send_request(make_req(KIND_POP, '0, '0));
        send_request(make_req(KIND_TAIL, '0, '0));
        send_request(make_req(KIND_UNDEFINED, {POS_W{1'b1}}, {VAL_W{1'b1}}));
        send_request(make_req(KIND_INSERT, {POS_W{1'b1}}, 64'h1234_5678_9ABC_DEF0));
        send_request(make_req(KIND_CLEAR, '0, '0));
    endtask

    task automatic test_basic_ops();
        send_request(make_req(KIND_INSERT, '0, 64'hFFFF_FFFF_FFFF_FF80));
        send_request(make_req(KIND_INSERT, '0, 64'h0000_0000_0000_007F));
        send_request(make_req(KIND_INSERT, {POS_W{1'b1}}, 64'h0000_0000_0000_00AB));
        send_request(make_req(KIND_GET, 16'd0, '0));
        send_request(make_req(KIND_GET, 16'd1, '0));
        send_request(make_req(KIND_GET, 16'd2, '0));
        send_request(make_req(KIND_GET, 16'd3, '0));
        send_request(make_req(KIND_SET, 16'd2, 64'hFEDC_BA98_7654_3210));
        send_request(make_req(KIND_TAIL, '0, '0));
        send_request(make_req(KIND_REMOVE, 16'd0, '0));
        send_request(make_req(KIND_GET, 16'd0, '0));
        send_request(make_req(KIND_POP, '0, '0));
    endtask

    // Covers the unmapped address, the undefined types and a type change over held data.
    task automatic test_register_port();
        drain_results();
        apb_transfer(ADDR_UNMAPPED, 1'b1, 32'hFFFF_FFF7);
        apb_transfer(ADDR_ELEMENT_TYPE, 1'b0, '0);
        set_element_type(TYPE_UINT64);
        send_request(make_req(KIND_INSERT, '0, {VAL_W{1'b1}}));
        send_request(make_req(KIND_GET, '0, '0));
        set_element_type(TYPE_INT16);
        send_request(make_req(KIND_TAIL, '0, '0));
        set_element_type(4'hF);
        send_request(make_req(KIND_POP, '0, '0));
        send_request(make_req(KIND_CLEAR, '0, '0));
    endtask

    task automatic test_fill_to_capacity();
        int i;
        set_element_type(TYPE_DOUBLE);
        send_request(make_req(KIND_CLEAR, '0, '0));
        for (i = 0; i < STORE_DEPTH; i++)
            send_request(make_req(KIND_INSERT, POS_W'($urandom_range(STORE_DEPTH, 65535)),
                                  random_value()));
        send_request(make_req(KIND_INSERT, '0, random_value()));
        send_request(make_req(KIND_GET, POS_W'(STORE_DEPTH - 1), '0));
        send_request(make_req(KIND_GET, POS_W'(STORE_DEPTH), '0));
        send_request(make_req(KIND_REMOVE, '0, '0));
        send_request(make_req(KIND_INSERT, '0, random_value()));
        send_request(make_req(KIND_GET, '0, '0));
        send_request(make_req(KIND_POP, '0, '0));
        send_request(make_req(KIND_TAIL, '0, '0));
    endtask

    // Chunks of random traffic; the element type changes between chunks over held data.
    task automatic test_random_traffic();
        int chunk;
        int n;
        int idle_pct;
        int target;
        for (chunk = 0; chunk < 14; chunk++)
        begin
            idle_pct = (chunk < 5) ? 11 : (chunk < 10) ? 50 : 0;
            target   = (chunk == 7) ? STORE_DEPTH : 24;
            set_element_type((chunk < 10) ? 4'(chunk) : 4'($urandom_range(10, 15)));
            for (n = 0; n < 80; n++)
            begin
                send_request(random_request(target));
                if ($urandom_range(99) < idle_pct)
                    pause_sender($urandom_range(1, 4));
                if ($urandom_range(99) == 0)
                    drain_results();
            end
        end
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && done)
        begin
            if (outcome_q.size() == 0)
            begin
                $error("result with no request outstanding: %h", result);
                fail_count++;
            end
            else
            begin
                want = outcome_q.pop_front();
                if (result.value_out !== want.value_out)
                begin
                    $error("value_out: expected %h, actual %h", want.value_out,
                           result.value_out);
                    fail_count++;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, result.status);
                    fail_count++;
                end
                if (result.count !== want.count)
                begin
                    $error("count: expected %0d, actual %0d", want.count, result.count);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL typed_shift_array_engine_core");
            $finish;
        end
    end

    initial
    begin
        int i;
        rst_n        = 1'b0;
        start        = 1'b0;
        request      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        fail_count   = 0;
        quiet_cycles = 0;
        mirror_fill  = 0;
        mirror_type  = TYPE_INT8;
        for (i = 0; i < STORE_DEPTH; i++)
            mirror_store[i] = '0;
        repeat (3)
            @(negedge clk);
        rst_n = 1'b1;

        test_empty_store();
        test_basic_ops();
        test_register_port();
        test_fill_to_capacity();
        test_random_traffic();

        drain_results();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (fail_count == 0)
            $display("PASS typed_shift_array_engine_core");
        else
            $display("FAIL typed_shift_array_engine_core");
        $finish;
    end

endmodule

### files.f
src/tsae_pkg.sv
src/tsae_ctrl.sv
src/tsae_datapath.sv
src/typed_shift_array_engine_core.sv
tb/tb_typed_shift_array_engine_core.sv
